// ===== rtl/rle_pkg.sv =====
package rle_pkg;

    // Selector carried in tuser of the input stream.
    typedef enum logic [1:0] {
        FUNC_TXN     = 2'd0,
        FUNC_CLOSE   = 2'd1,
        FUNC_RESTART = 2'd2
    } func_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_LOW  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_HIGH = 1'b1;

    // Input request layout.
    localparam int FIELD_TIME_BITS   = 32;
    localparam int FIELD_AMOUNT_BITS = 31;
    localparam int OFS_TIME          = 0;
    localparam int OFS_WIN_START     = 32;
    localparam int OFS_WIN_END       = 64;
    localparam int OFS_AMOUNT_LOW    = 96;
    localparam int OFS_AMOUNT_HIGH   = 127;
    localparam int OFS_CONSUMES      = 158;
    localparam int IN_DATA_BITS      = 160;
    localparam int IN_USER_BITS      = 2;

    // Result layout: four 48-bit level bounds, then eight 47-bit sums.
    localparam int OUT_LEVEL_BITS = 48;
    localparam int OUT_SUM_BITS   = 47;
    localparam int OUT_DATA_BITS  = 568;

endpackage

// ===== rtl/resource_level_envelope_core.sv =====
// Resource level envelope over a stream of time instants.
//
// Input requests arrive on the s_axis channel. tuser selects the kind of
// request: a transaction, an instant with no transactions, or a restart that
// reloads the initial capacity from the two configuration registers. tlast on
// a transaction marks the final transaction of the instant and closes it.
// Each closed instant produces one result on the m_axis channel carrying the
// four level bounds and the eight consumption and production sums.
//
// The block takes one request per cycle. A request is registered at the input,
// then all accumulator updates and the result are computed combinationally
// into the state and the result register, so a result passes the input
// register and then the result register. While a result waits on a stalled
// receiver, requests that do not close an instant keep flowing; the next
// closing request is held in the input register and s_axis_tready drops until
// the pending result is taken.
//
// Reset clears all accumulators and both configuration registers to zero.
// Configuration writes are taken on any cycle in which cfg_we is high and
// must only be issued while no request is in flight.
module resource_level_envelope_core
    import rle_pkg::*;
#(
    parameter int AMOUNT_BITS = 31,
    parameter int LEVEL_BITS  = 48,
    parameter int TIME_BITS   = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // instant_time, window_start, window_end, amount_low, amount_high,
    // consumes, one pad bit
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    // func
    input  logic [IN_USER_BITS-1:0]   s_axis_tuser,
    // last_of_instant
    input  logic                      s_axis_tlast,

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // lower_level_min, lower_level_max, upper_level_min, upper_level_max,
    // instant_use_min, instant_use_max, instant_supply_min, instant_supply_max,
    // total_use_min, total_use_max, total_supply_min, total_supply_max
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata
);

    typedef logic signed [LEVEL_BITS-1:0] level_t;

    localparam int TW = (TIME_BITS < FIELD_TIME_BITS) ? TIME_BITS : FIELD_TIME_BITS;
    localparam logic signed [63:0] LMAX_S = (64'sd1 <<< (LEVEL_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] LMIN_S = -LMAX_S - 64'sd1;
    localparam logic [63:0] LMAX_U   = LMAX_S;
    localparam logic [63:0] AMT_MASK = (64'd1 << AMOUNT_BITS) - 64'd1;
    localparam level_t LMAX_L = LMAX_S[LEVEL_BITS-1:0];
    localparam level_t LMIN_L = LMIN_S[LEVEL_BITS-1:0];
    localparam level_t ZERO_L = '0;

    function automatic level_t sat_add(level_t a, level_t b);
        logic signed [LEVEL_BITS:0] s;
        s = (LEVEL_BITS + 1)'(a) + (LEVEL_BITS + 1)'(b);
        if (s[LEVEL_BITS] != s[LEVEL_BITS-1])
            sat_add = s[LEVEL_BITS] ? LMIN_L : LMAX_L;
        else
            sat_add = s[LEVEL_BITS-1:0];
    endfunction

    function automatic level_t sat_sub(level_t a, level_t b);
        logic signed [LEVEL_BITS:0] s;
        s = (LEVEL_BITS + 1)'(a) - (LEVEL_BITS + 1)'(b);
        if (s[LEVEL_BITS] != s[LEVEL_BITS-1])
            sat_sub = s[LEVEL_BITS] ? LMIN_L : LMAX_L;
        else
            sat_sub = s[LEVEL_BITS-1:0];
    endfunction

    function automatic level_t amount_of(logic [FIELD_AMOUNT_BITS-1:0] raw);
        logic [63:0] v;
        v = 64'(raw) & AMT_MASK;
        if (v > LMAX_U)
            v = LMAX_U;
        amount_of = v[LEVEL_BITS-1:0];
    endfunction

    function automatic level_t level_of_reg(logic [CFG_DATA_BITS-1:0] raw);
        logic signed [63:0] s;
        s = 64'(signed'(raw));
        if (s > LMAX_S)
            s = LMAX_S;
        else if (s < LMIN_S)
            s = LMIN_S;
        level_of_reg = s[LEVEL_BITS-1:0];
    endfunction

    function automatic logic [OUT_LEVEL_BITS-1:0] out_level(level_t x);
        logic signed [63:0] w;
        w = 64'(x);
        out_level = w[OUT_LEVEL_BITS-1:0];
    endfunction

    function automatic logic [OUT_SUM_BITS-1:0] out_sum(level_t x);
        logic signed [63:0] w;
        w = 64'(x);
        out_sum = w[OUT_SUM_BITS-1:0];
    endfunction

    // Configuration registers.
    logic [CFG_DATA_BITS-1:0] init_low_reg;
    logic [CFG_DATA_BITS-1:0] init_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_low_reg  <= '0;
            init_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INIT_LOW:  init_low_reg  <= cfg_data;
                CFG_INIT_HIGH: init_high_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input register. Amount clamping and time compares are done ahead of it.
    logic   in_valid_reg;
    func_t  func_reg;
    logic   last_reg;
    logic   cons_reg;
    logic   single_reg;
    logic   at_start_reg;
    logic   at_end_reg;
    level_t lo_reg;
    level_t hi_reg;

    logic   in_accept;
    logic   advance;
    logic   emits;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign emits         = (func_reg == FUNC_CLOSE) || ((func_reg == FUNC_TXN) && last_reg);
    assign advance       = in_valid_reg && (!emits || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg     <= func_t'(s_axis_tuser);
            last_reg     <= s_axis_tlast;
            cons_reg     <= s_axis_tdata[OFS_CONSUMES];
            single_reg   <= s_axis_tdata[OFS_WIN_START +: TW] == s_axis_tdata[OFS_WIN_END +: TW];
            at_start_reg <= s_axis_tdata[OFS_WIN_START +: TW] == s_axis_tdata[OFS_TIME +: TW];
            at_end_reg   <= s_axis_tdata[OFS_WIN_END +: TW] == s_axis_tdata[OFS_TIME +: TW];
            lo_reg       <= amount_of(s_axis_tdata[OFS_AMOUNT_LOW +: FIELD_AMOUNT_BITS]);
            hi_reg       <= amount_of(s_axis_tdata[OFS_AMOUNT_HIGH +: FIELD_AMOUNT_BITS]);
        end
    end

    // Accumulators.
    level_t lower_min_reg, lower_max_reg, upper_min_reg, upper_max_reg;
    level_t prior_use_min_reg, prior_use_max_reg, prior_supply_min_reg, prior_supply_max_reg;
    level_t now_use_min_reg, now_use_max_reg, now_supply_min_reg, now_supply_max_reg;
    level_t end_use_min_reg, end_use_max_reg, end_supply_min_reg, end_supply_max_reg;

    level_t lower_min_next, lower_max_next, upper_min_next, upper_max_next;
    level_t prior_use_min_next, prior_use_max_next, prior_supply_min_next, prior_supply_max_next;
    level_t now_use_min_next, now_use_max_next, now_supply_min_next, now_supply_max_next;
    level_t end_use_min_next, end_use_max_next, end_supply_min_next, end_supply_max_next;

    // Instant values after this request's transaction has been applied.
    level_t lmin_t, lmax_t, umin_t, umax_t;
    level_t nu_min_t, nu_max_t, ns_min_t, ns_max_t;
    level_t eu_min_t, eu_max_t, es_min_t, es_max_t;
    level_t tot_use_max, tot_supply_max;

    logic [OUT_DATA_BITS-1:0] out_data_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic                     out_valid_reg;

    always_comb
    begin
        lmin_t   = lower_min_reg;
        lmax_t   = lower_max_reg;
        umin_t   = upper_min_reg;
        umax_t   = upper_max_reg;
        nu_min_t = now_use_min_reg;
        nu_max_t = now_use_max_reg;
        ns_min_t = now_supply_min_reg;
        ns_max_t = now_supply_max_reg;
        eu_min_t = end_use_min_reg;
        eu_max_t = end_use_max_reg;
        es_min_t = end_supply_min_reg;
        es_max_t = end_supply_max_reg;

        if (func_reg == FUNC_TXN)
        begin
            if (cons_reg)
            begin
                if (single_reg)
                    nu_min_t = sat_add(nu_min_t, lo_reg);
                nu_max_t = sat_add(nu_max_t, hi_reg);
            end
            else
            begin
                if (single_reg)
                    ns_min_t = sat_add(ns_min_t, lo_reg);
                ns_max_t = sat_add(ns_max_t, hi_reg);
            end

            // Window opening at the instant is applied before window closing.
            if (at_start_reg)
            begin
                if (cons_reg)
                begin
                    lmin_t = sat_sub(lmin_t, hi_reg);
                    lmax_t = sat_sub(lmax_t, lo_reg);
                end
                else
                begin
                    umin_t = sat_add(umin_t, lo_reg);
                    umax_t = sat_add(umax_t, hi_reg);
                end
            end
            if (at_end_reg)
            begin
                if (cons_reg)
                begin
                    umax_t   = sat_sub(umax_t, lo_reg);
                    umin_t   = sat_sub(umin_t, hi_reg);
                    eu_min_t = sat_add(eu_min_t, lo_reg);
                    eu_max_t = sat_add(eu_max_t, hi_reg);
                end
                else
                begin
                    lmin_t   = sat_add(lmin_t, lo_reg);
                    lmax_t   = sat_add(lmax_t, hi_reg);
                    es_min_t = sat_add(es_min_t, lo_reg);
                    es_max_t = sat_add(es_max_t, hi_reg);
                end
            end
        end

        tot_use_max    = sat_add(prior_use_max_reg, nu_max_t);
        tot_supply_max = sat_add(prior_supply_max_reg, ns_max_t);

        lower_min_next        = lmin_t;
        lower_max_next        = lmax_t;
        upper_min_next        = umin_t;
        upper_max_next        = umax_t;
        now_use_min_next      = nu_min_t;
        now_use_max_next      = nu_max_t;
        now_supply_min_next   = ns_min_t;
        now_supply_max_next   = ns_max_t;
        end_use_min_next      = eu_min_t;
        end_use_max_next      = eu_max_t;
        end_supply_min_next   = es_min_t;
        end_supply_max_next   = es_max_t;
        prior_use_min_next    = prior_use_min_reg;
        prior_use_max_next    = prior_use_max_reg;
        prior_supply_min_next = prior_supply_min_reg;
        prior_supply_max_next = prior_supply_max_reg;

        if (emits)
        begin
            // The minimum totals equal the folded prior minimums.
            prior_use_min_next    = sat_add(prior_use_min_reg, eu_min_t);
            prior_use_max_next    = sat_add(prior_use_max_reg, eu_max_t);
            prior_supply_min_next = sat_add(prior_supply_min_reg, es_min_t);
            prior_supply_max_next = sat_add(prior_supply_max_reg, es_max_t);
        end

        if (emits || (func_reg == FUNC_RESTART))
        begin
            now_use_min_next    = ZERO_L;
            now_use_max_next    = ZERO_L;
            now_supply_min_next = ZERO_L;
            now_supply_max_next = ZERO_L;
            end_use_min_next    = ZERO_L;
            end_use_max_next    = ZERO_L;
            end_supply_min_next = ZERO_L;
            end_supply_max_next = ZERO_L;
        end

        if (func_reg == FUNC_RESTART)
        begin
            lower_min_next        = level_of_reg(init_low_reg);
            lower_max_next        = level_of_reg(init_low_reg);
            upper_min_next        = level_of_reg(init_high_reg);
            upper_max_next        = level_of_reg(init_high_reg);
            prior_use_min_next    = ZERO_L;
            prior_use_max_next    = ZERO_L;
            prior_supply_min_next = ZERO_L;
            prior_supply_max_next = ZERO_L;
        end

        out_data_next = {
            out_sum(tot_supply_max),
            out_sum(prior_supply_min_next),
            out_sum(tot_use_max),
            out_sum(prior_use_min_next),
            out_sum(ns_max_t),
            out_sum(ns_min_t),
            out_sum(nu_max_t),
            out_sum(nu_min_t),
            out_level(umax_t),
            out_level(umin_t),
            out_level(lmax_t),
            out_level(lmin_t)
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_min_reg        <= '0;
            lower_max_reg        <= '0;
            upper_min_reg        <= '0;
            upper_max_reg        <= '0;
            prior_use_min_reg    <= '0;
            prior_use_max_reg    <= '0;
            prior_supply_min_reg <= '0;
            prior_supply_max_reg <= '0;
            now_use_min_reg      <= '0;
            now_use_max_reg      <= '0;
            now_supply_min_reg   <= '0;
            now_supply_max_reg   <= '0;
            end_use_min_reg      <= '0;
            end_use_max_reg      <= '0;
            end_supply_min_reg   <= '0;
            end_supply_max_reg   <= '0;
        end
        else if (advance)
        begin
            lower_min_reg        <= lower_min_next;
            lower_max_reg        <= lower_max_next;
            upper_min_reg        <= upper_min_next;
            upper_max_reg        <= upper_max_next;
            prior_use_min_reg    <= prior_use_min_next;
            prior_use_max_reg    <= prior_use_max_next;
            prior_supply_min_reg <= prior_supply_min_next;
            prior_supply_max_reg <= prior_supply_max_next;
            now_use_min_reg      <= now_use_min_next;
            now_use_max_reg      <= now_use_max_next;
            now_supply_min_reg   <= now_supply_min_next;
            now_supply_max_reg   <= now_supply_max_next;
            end_use_min_reg      <= end_use_min_next;
            end_use_max_reg      <= end_use_max_next;
            end_supply_min_reg   <= end_supply_min_next;
            end_supply_max_reg   <= end_supply_max_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emits)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emits)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A closing request always leaves a result behind.
    a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emits) |=> out_valid_reg)
        else $error("closing request did not load the result register");

    // A closing request must never overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !(advance && emits))
        else $error("pending result overwritten");

    // Restart clears the prior and instant sums.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && func_reg == FUNC_RESTART) |=>
        (prior_use_min_reg == ZERO_L) && (prior_supply_max_reg == ZERO_L) &&
        (now_use_max_reg == ZERO_L) && (end_supply_min_reg == ZERO_L))
        else $error("restart left sums behind");

    // Sums of clamped amounts never go negative.
    a_sums_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !prior_use_min_reg[LEVEL_BITS-1] && !prior_supply_max_reg[LEVEL_BITS-1] &&
        !now_use_max_reg[LEVEL_BITS-1] && !end_supply_min_reg[LEVEL_BITS-1])
        else $error("consumption or production sum went negative");

endmodule
